FILE: hw/rtl/stap_pkg.sv
// ----------------------------------------------------------------------------
// Sprite table access port: shared definitions
// Access kinds, widths and the command bundles passed between the access
// control logic and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stap_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PtrW   = 10;
  // The store is split into an even-byte bank and an odd-byte bank
  localparam int unsigned RowW   = PtrW - 1;
  localparam int unsigned BankDepth = 2 ** RowW;

  typedef enum logic [1:0] {
    KindAddrLow  = 2'd0,
    KindAddrHigh = 2'd1,
    KindDataWr   = 2'd2,
    KindDataRd   = 2'd3
  } kind_e;

  // Store access for one cycle, both banks share the row
  typedef struct packed {
    logic             re;
    logic             we_even;
    logic             we_odd;
    logic [RowW-1:0]  row;
    logic [ByteW-1:0] wdata_even;
    logic [ByteW-1:0] wdata_odd;
  } ram_cmd_t;

  // Pair latch bypass from the read stage
  typedef struct packed {
    logic             hit;   // even read waiting in the read stage
    logic             upd;   // that read leaves the stage this cycle
    logic [ByteW-1:0] data;
  } lat_fwd_t;

endpackage

FILE: hw/rtl/stap_in_if.sv
// ----------------------------------------------------------------------------
// Sprite table access port: access channel
// Valid/ready channel carrying one bus access per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stap_in_if;
  logic                         valid;
  logic                         ready;
  stap_pkg::kind_e              kind;
  logic [stap_pkg::ByteW-1:0]   data;

  modport source (output valid, output kind, output data, input ready);
  modport sink   (input valid, input kind, input data, output ready);
endinterface

FILE: hw/rtl/stap_out_if.sv
// ----------------------------------------------------------------------------
// Sprite table access port: result channel
// Valid/ready channel carrying one result item per access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stap_out_if;
  logic                         valid;
  logic                         ready;
  logic [stap_pkg::ByteW-1:0]   read_data;
  logic [stap_pkg::PtrW-1:0]    pointer_after;

  modport source (output valid, output read_data, output pointer_after, input ready);
  modport sink   (input valid, input read_data, input pointer_after, output ready);
endinterface

FILE: hw/rtl/stap_ram.sv
// ----------------------------------------------------------------------------
// Sprite table access port: generic RAM
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/stap_access.sv
// ----------------------------------------------------------------------------
// Sprite table access port: access control
// Address registers, byte pointer, pair latch, store command decode and the
// clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stap_access (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  stap_pkg::kind_e             kind_i,
  input  logic [stap_pkg::ByteW-1:0]  data_i,
  input  stap_pkg::lat_fwd_t          lat_fwd_i,
  output stap_pkg::ram_cmd_t          cmd_o,
  output logic [stap_pkg::PtrW-1:0]   ptr_next_o,
  output logic                        busy_o
);

  logic [stap_pkg::ByteW-1:0] addr_low_q, addr_low_d;
  logic                       addr_high_q, addr_high_d;
  logic [stap_pkg::PtrW-1:0]  ptr_q, ptr_d;
  logic [stap_pkg::ByteW-1:0] latch_q, latch_d;
  logic [stap_pkg::ByteW-1:0] latch_eff;
  logic                       clr_q, clr_d;
  logic [stap_pkg::RowW-1:0]  clr_row_q, clr_row_d;
  stap_pkg::ram_cmd_t         cmd;

  // Latch as seen by this item: an even read still in flight owns it
  assign latch_eff = lat_fwd_i.hit ? lat_fwd_i.data : latch_q;

  // Decode of the accepted access
  always_comb begin
    addr_low_d  = addr_low_q;
    addr_high_d = addr_high_q;
    ptr_d       = ptr_q;
    latch_d     = latch_q;
    clr_d       = clr_q;
    clr_row_d   = clr_row_q;
    cmd         = '0;
    cmd.row     = ptr_q[stap_pkg::PtrW-1:1];

    if (lat_fwd_i.upd) begin
      latch_d = lat_fwd_i.data;
    end

    if (clr_q) begin
      // Zero one row of both banks per cycle
      cmd.row        = clr_row_q;
      cmd.we_even    = 1'b1;
      cmd.we_odd     = 1'b1;
      clr_row_d      = clr_row_q + stap_pkg::RowW'(1);
      if (clr_row_q == {stap_pkg::RowW{1'b1}}) begin
        clr_d = 1'b0;
      end
    end else if (accept_i) begin
      unique case (kind_i)
        stap_pkg::KindAddrLow: begin
          addr_low_d = data_i;
          ptr_d      = {addr_high_q, data_i, 1'b0};
        end
        stap_pkg::KindAddrHigh: begin
          addr_high_d = data_i[0];
          ptr_d       = {data_i[0], addr_low_q, 1'b0};
        end
        stap_pkg::KindDataWr: begin
          cmd.wdata_even = data_i;
          cmd.wdata_odd  = data_i;
          if (ptr_q[stap_pkg::PtrW-1]) begin
            // Upper half: direct byte store
            if (!ptr_q[0]) begin
              latch_d     = data_i;
              cmd.we_even = 1'b1;
            end else begin
              cmd.we_odd  = 1'b1;
            end
          end else if (!ptr_q[0]) begin
            latch_d = data_i;
          end else begin
            // Lower half odd byte: commit the pair
            cmd.we_even    = 1'b1;
            cmd.we_odd     = 1'b1;
            cmd.wdata_even = latch_eff;
          end
          ptr_d = ptr_q + stap_pkg::PtrW'(1);
        end
        stap_pkg::KindDataRd: begin
          cmd.re = 1'b1;
          ptr_d  = ptr_q + stap_pkg::PtrW'(1);
        end
        default: begin
          ptr_d = ptr_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_low_q  <= '0;
      addr_high_q <= 1'b0;
      ptr_q       <= '0;
      latch_q     <= '0;
      clr_q       <= 1'b1;
      clr_row_q   <= '0;
    end else begin
      addr_low_q  <= addr_low_d;
      addr_high_q <= addr_high_d;
      ptr_q       <= ptr_d;
      latch_q     <= latch_d;
      clr_q       <= clr_d;
      clr_row_q   <= clr_row_d;
    end
  end

  assign cmd_o      = cmd;
  assign ptr_next_o = ptr_d;
  assign busy_o     = clr_q;

endmodule

FILE: hw/rtl/sprite_table_access_port.sv
// ----------------------------------------------------------------------------
// Sprite table access port
// Bus access port to a 1024-byte sprite attribute store.
// ----------------------------------------------------------------------------
// One access item is taken per cycle unless the store is being cleared or the
// result side stalls; its result passes the read stage and result register.
// The rate is set by the store banks, each taking one access per cycle with a
// registered read. The store is an even and an odd bank of 512 bytes so that
// a pair write stores both bytes together. After reset the block zeroes the
// store, one row of both banks a cycle, and accepts no item until that pass is done.
`timescale 1ns / 1ps

module sprite_table_access_port (
  input  logic clk_i,
  input  logic rst_ni,
  stap_in_if.sink    in_i,
  stap_out_if.source out_o
);

  logic                       accept;
  logic                       busy;
  logic                       s1_adv;
  stap_pkg::ram_cmd_t         cmd;
  stap_pkg::lat_fwd_t         lat_fwd;
  logic [stap_pkg::PtrW-1:0]  ptr_next;
  logic [stap_pkg::ByteW-1:0] even_rdata, odd_rdata;

  // Read stage: waits for the bank data
  logic                       s1_valid_q;
  logic                       s1_read_q;
  logic                       s1_odd_q;
  logic [stap_pkg::PtrW-1:0]  s1_ptr_q;

  // Result register
  logic                       out_valid_q;
  logic [stap_pkg::ByteW-1:0] out_rdata_q;
  logic [stap_pkg::PtrW-1:0]  out_ptr_q;

  // Byte lane of a read: the pointer before the access, one below the next one
  function automatic logic u_odd_sel(stap_pkg::kind_e kind,
                                     logic [stap_pkg::PtrW-1:0] nxt);
    logic sel;
    sel = 1'b0;
    if (kind == stap_pkg::KindDataRd) begin
      sel = !nxt[0];
    end
    return sel;
  endfunction

  // Handshake
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !busy && (!s1_valid_q || s1_adv);
  assign accept     = in_i.valid && in_i.ready;

  // Even read in flight feeds the pair latch
  assign lat_fwd.hit  = s1_valid_q && s1_read_q && !s1_odd_q;
  assign lat_fwd.upd  = lat_fwd.hit && s1_adv;
  assign lat_fwd.data = even_rdata;

  stap_access u_access (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (in_i.kind),
    .data_i     (in_i.data),
    .lat_fwd_i  (lat_fwd),
    .cmd_o      (cmd),
    .ptr_next_o (ptr_next),
    .busy_o     (busy)
  );

  stap_ram #(
    .Width (stap_pkg::ByteW),
    .Depth (stap_pkg::BankDepth)
  ) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (cmd.we_even),
    .re_i    (cmd.re),
    .addr_i  (cmd.row),
    .wdata_i (cmd.wdata_even),
    .rdata_o (even_rdata)
  );

  stap_ram #(
    .Width (stap_pkg::ByteW),
    .Depth (stap_pkg::BankDepth)
  ) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (cmd.we_odd),
    .re_i    (cmd.re),
    .addr_i  (cmd.row),
    .wdata_i (cmd.wdata_odd),
    .rdata_o (odd_rdata)
  );

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q <= (in_i.kind == stap_pkg::KindDataRd);
      s1_odd_q  <= u_odd_sel(in_i.kind, ptr_next);
      s1_ptr_q  <= ptr_next;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_rdata_q <= !s1_read_q ? '0 : (s1_odd_q ? odd_rdata : even_rdata);
      out_ptr_q   <= s1_ptr_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = out_rdata_q;
  assign out_o.pointer_after = out_ptr_q;

  // Checks
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready)
    else $error("item accepted during the clearing pass");

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.re |-> !(cmd.we_even || cmd.we_odd))
    else $error("store read and write in the same cycle");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_ptr_q)))
    else $error("read stage item lost while the result side stalls");

  a_clear_blocks_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (!cmd.re && cmd.we_even && cmd.we_odd))
    else $error("clearing pass not writing both banks");

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Sprite table access port: testbench
// Drives bus accesses into the port and checks each result item against an
// in-bench model of the pointer, the pair latch and the 1024-byte store.
// Directed accesses come first, then random traffic under several idling
// phases on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam logic [stap_pkg::PtrW-1:0] DirectBase = 10'h200;
  localparam int unsigned     RandomItemsPerPhase = 350;
  localparam int unsigned     DrainCycles = 8;

  typedef struct packed {
    logic [stap_pkg::ByteW-1:0] read_data;
    logic [stap_pkg::PtrW-1:0]  pointer_after;
  } access_result_t;

  logic clk;
  logic rst_n;

  stap_in_if  acc_bus ();
  stap_out_if res_bus ();

  sprite_table_access_port u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (acc_bus.sink),
    .out_o  (res_bus.source)
  );

  // Model state
  logic [stap_pkg::ByteW-1:0] word_lo;
  logic                       word_hi;
  logic [stap_pkg::PtrW-1:0]  byte_ptr;
  logic [stap_pkg::ByteW-1:0] pair_latch;
  logic [stap_pkg::ByteW-1:0] sprite_mem [2**stap_pkg::PtrW];

  access_result_t results_due [$];
  int unsigned    gap_pct;
  int unsigned    stall_pct;
  int unsigned    items_sent;
  int unsigned    mismatches;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the port hangs
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Model of one access: updates the state and returns the result item
  function automatic access_result_t compute_access_result(
      stap_pkg::kind_e kind, logic [stap_pkg::ByteW-1:0] data);
    access_result_t            res;
    logic [stap_pkg::PtrW-1:0] p;
    logic [stap_pkg::PtrW-1:0] even_p;
    res.read_data = '0;
    p = byte_ptr;
    even_p = {p[stap_pkg::PtrW-1:1], 1'b0};
    case (kind)
      stap_pkg::KindAddrLow: begin
        word_lo  = data;
        byte_ptr = {word_hi, word_lo, 1'b0};
      end
      stap_pkg::KindAddrHigh: begin
        // only bit 0 reaches the word address
        word_hi  = data[0];
        byte_ptr = {word_hi, word_lo, 1'b0};
      end
      stap_pkg::KindDataWr: begin
        if (p >= DirectBase) begin
          if (!p[0]) pair_latch = data;
          sprite_mem[p] = data;
        end else if (!p[0]) begin
          pair_latch = data;
        end else begin
          sprite_mem[even_p] = pair_latch;
          sprite_mem[even_p + stap_pkg::PtrW'(1)] = data;
        end
        byte_ptr = p + stap_pkg::PtrW'(1);
      end
      default: begin
        res.read_data = sprite_mem[p];
        if (!p[0]) pair_latch = sprite_mem[p];
        byte_ptr = p + stap_pkg::PtrW'(1);
      end
    endcase
    res.pointer_after = byte_ptr;
    return res;
  endfunction

  // Send one access item, with a random gap ahead of it
  task automatic send_access(stap_pkg::kind_e kind, logic [stap_pkg::ByteW-1:0] data);
    if ($urandom_range(99) < gap_pct) begin
      acc_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    acc_bus.valid <= 1'b1;
    acc_bus.kind  <= kind;
    acc_bus.data  <= data;
    do @(posedge clk); while (!(acc_bus.valid && acc_bus.ready));
    results_due.push_back(compute_access_result(kind, data));
    items_sent++;
  endtask

  // Load a word address; junk in the unused high bits, either order
  task automatic set_word_addr(logic [stap_pkg::RowW-1:0] word);
    logic [stap_pkg::ByteW-1:0] hi_byte;
    hi_byte = {7'($urandom_range(127)), word[stap_pkg::RowW-1]};
    if ($urandom_range(1)) begin
      send_access(stap_pkg::KindAddrHigh, hi_byte);
      send_access(stap_pkg::KindAddrLow, word[stap_pkg::ByteW-1:0]);
    end else begin
      send_access(stap_pkg::KindAddrLow, word[stap_pkg::ByteW-1:0]);
      send_access(stap_pkg::KindAddrHigh, hi_byte);
    end
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin : check_results
    access_result_t due;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result item: read_data %0h pointer_after %0h",
                 res_bus.read_data, res_bus.pointer_after);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          if (res_bus.read_data !== due.read_data) begin
            $error("read_data: expected %0h, actual %0h", due.read_data, res_bus.read_data);
            mismatches++;
          end
          if (res_bus.pointer_after !== due.pointer_after) begin
            $error("pointer_after: expected %0h, actual %0h",
                   due.pointer_after, res_bus.pointer_after);
            mismatches++;
          end
        end
      end
      res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Address loading, high-bit masking and wrap at the top of the store
  task automatic test_address_and_wrap();
    send_access(stap_pkg::KindAddrLow, 8'hFF);
    send_access(stap_pkg::KindAddrHigh, 8'hFF);
    send_access(stap_pkg::KindDataWr, 8'hA5);
    send_access(stap_pkg::KindDataWr, 8'h5A);
    send_access(stap_pkg::KindDataRd, 8'hFF);
    send_access(stap_pkg::KindAddrHigh, 8'hFE);
    send_access(stap_pkg::KindAddrLow, 8'h00);
  endtask

  // Pair writes below the direct region, then read back
  task automatic test_pair_writes();
    send_access(stap_pkg::KindDataWr, 8'h11);
    send_access(stap_pkg::KindDataWr, 8'h22);
    send_access(stap_pkg::KindDataWr, 8'hFF);
    send_access(stap_pkg::KindDataWr, 8'h00);
    send_access(stap_pkg::KindAddrLow, 8'h00);
    send_access(stap_pkg::KindDataRd, 8'h00);
    send_access(stap_pkg::KindDataRd, 8'hFF);
    send_access(stap_pkg::KindDataRd, 8'h00);
  endtask

  // Direct region writes, and a read at the top of the store
  task automatic test_direct_region();
    send_access(stap_pkg::KindAddrHigh, 8'h01);
    send_access(stap_pkg::KindAddrLow, 8'h00);
    send_access(stap_pkg::KindDataWr, 8'h00);
    send_access(stap_pkg::KindDataWr, 8'hFF);
    send_access(stap_pkg::KindAddrLow, 8'hFF);
    send_access(stap_pkg::KindDataRd, 8'h00);
    send_access(stap_pkg::KindDataRd, 8'h00);
  endtask

  // An even read refills the latch used by the next odd write
  task automatic test_read_latch();
    send_access(stap_pkg::KindAddrHigh, 8'h00);
    send_access(stap_pkg::KindAddrLow, 8'h00);
    send_access(stap_pkg::KindDataRd, 8'h00);
    send_access(stap_pkg::KindDataWr, 8'h99);
    send_access(stap_pkg::KindAddrLow, 8'h00);
    send_access(stap_pkg::KindDataRd, 8'h00);
    send_access(stap_pkg::KindDataRd, 8'h00);
  endtask

  // Random traffic: mostly write bursts read back, some mixed, some noise
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned               stop_at;
    int unsigned               burst;
    int unsigned               pick;
    logic [stap_pkg::RowW-1:0] word;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      word = stap_pkg::RowW'($urandom_range(2**stap_pkg::RowW - 1));
      burst = $urandom_range(16, 1);
      if (pick < 70) begin
        set_word_addr(word);
        if ($urandom_range(3) == 0) begin
          send_access(stap_pkg::KindDataRd, stap_pkg::ByteW'($urandom_range(255)));
        end
        repeat (burst) send_access(stap_pkg::KindDataWr, stap_pkg::ByteW'($urandom_range(255)));
        set_word_addr(word);
        repeat (burst + 1) begin
          send_access(stap_pkg::KindDataRd, stap_pkg::ByteW'($urandom_range(255)));
        end
      end else if (pick < 85) begin
        set_word_addr(word);
        repeat (burst) begin
          if ($urandom_range(1)) begin
            send_access(stap_pkg::KindDataWr, stap_pkg::ByteW'($urandom_range(255)));
          end else begin
            send_access(stap_pkg::KindDataRd, stap_pkg::ByteW'($urandom_range(255)));
          end
        end
      end else begin
        send_access(stap_pkg::kind_e'($urandom_range(3)),
                    stap_pkg::ByteW'($urandom_range(255)));
      end
    end
  endtask

  // Stimulus
  initial begin
    word_lo    = '0;
    word_hi    = 1'b0;
    byte_ptr   = '0;
    pair_latch = '0;
    foreach (sprite_mem[i]) sprite_mem[i] = '0;
    gap_pct    = 0;
    stall_pct  = 0;
    items_sent = 0;
    mismatches = 0;

    rst_n         = 1'b0;
    acc_bus.valid = 1'b0;
    acc_bus.kind  = stap_pkg::KindAddrLow;
    acc_bus.data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_address_and_wrap();
    test_pair_writes();
    test_direct_region();
    test_read_latch();

    test_random_traffic(RandomItemsPerPhase);
    gap_pct = 55;
    test_random_traffic(RandomItemsPerPhase);
    gap_pct   = 0;
    stall_pct = 55;
    test_random_traffic(RandomItemsPerPhase);
    gap_pct   = 36;
    stall_pct = 36;
    test_random_traffic(RandomItemsPerPhase);

    acc_bus.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/stap_pkg.sv
hw/rtl/stap_in_if.sv
hw/rtl/stap_out_if.sv
hw/rtl/stap_ram.sv
hw/rtl/stap_access.sv
hw/rtl/sprite_table_access_port.sv
tb/sv/tb.sv
